@@ rtl/egop_pkg.sv @@
package egop_pkg;

    // Field widths
    localparam int CH_W       = 4;
    localparam int CH_CODES   = 16;
    localparam int AUD_W      = 16;
    localparam int CFG_DATA_W = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int COEF_W     = 18;
    localparam int NORM_W     = 17;
    localparam int GAIN_W     = 15;
    localparam int DEPTH_W    = 14;
    localparam int STATE_W    = 32;

    localparam int CHANNELS_DEF = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POLE_COEF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLE_NORM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_LOG2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CV_DEPTH  = 2'd3;

    localparam logic [COEF_W-1:0]         POLE_COEF_RST = 18'd1000;
    localparam logic [NORM_W-1:0]         POLE_NORM_RST = 17'd64527;
    localparam logic signed [GAIN_W-1:0]  GAIN_LOG2_RST = '0;
    localparam logic signed [DEPTH_W-1:0] CV_DEPTH_RST  = '0;

    // Shared multiplier
    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 19;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Exponent and 2^f polynomial, Q.16
    localparam int E_W        = 22;
    localparam int TENTH_Q16  = 6554;
    localparam int HORNER_C3  = 5129;
    localparam int HORNER_C2  = 14822;
    localparam int HORNER_C1  = 45584;
    localparam int HORNER_C0  = 65536;
    localparam int N_MIN      = -30;
    localparam int N_MAX      = 8;
    localparam int X_SHIFT_W  = 40;

    localparam int ACC_W  = 36;
    localparam int DIF_W  = 33;
    localparam int SUM_W  = 45;
    localparam int WGT_W  = 10;

    typedef enum logic [16:0] {
        ST_IDLE = 17'h00001,
        ST_MOD  = 17'h00002,
        ST_SCL  = 17'h00004,
        ST_EXP  = 17'h00008,
        ST_H1   = 17'h00010,
        ST_H2   = 17'h00020,
        ST_H3   = 17'h00040,
        ST_AUD  = 17'h00080,
        ST_XIN  = 17'h00100,
        ST_P1   = 17'h00200,
        ST_P2   = 17'h00400,
        ST_P3   = 17'h00800,
        ST_P4   = 17'h01000,
        ST_P5   = 17'h02000,
        ST_P6   = 17'h04000,
        ST_P7   = 17'h08000,
        ST_FIN  = 17'h10000
    } state_t;

    // Output weight for each of the four oversampled passes
    function automatic logic signed [WGT_W-1:0] tap_weight(input logic [1:0] k);
        logic signed [WGT_W-1:0] w;
        case (k)
            2'd0:    w = -10'sd120;
            2'd1:    w = 10'sd396;
            2'd2:    w = -10'sd440;
            default: w = 10'sd165;
        endcase
        return w;
    endfunction

    // Right shift by 16, rounded half up
    function automatic logic signed [MUL_P_W-1:0] rnd16(input logic signed [MUL_P_W-1:0] v);
        return (v + (MUL_P_W'(1) <<< 15)) >>> 16;
    endfunction

    function automatic logic signed [STATE_W-1:0] sat32(input logic signed [MUL_P_W-1:0] v);
        logic signed [STATE_W-1:0] r;
        if (v > MUL_P_W'(64'sh7FFF_FFFF))
            r = 32'sh7FFF_FFFF;
        else if (v < -(MUL_P_W'(64'sh8000_0000)))
            r = -32'sh8000_0000;
        else
            r = v[STATE_W-1:0];
        return r;
    endfunction

    function automatic logic signed [AUD_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
        logic signed [AUD_W-1:0] r;
        if (v > SUM_W'(32767))
            r = 16'sh7FFF;
        else if (v < -(SUM_W'(32768)))
            r = -16'sh8000;
        else
            r = v[AUD_W-1:0];
        return r;
    endfunction

endpackage

@@ rtl/egop_in_if.sv @@
interface egop_in_if;
    logic                                valid;
    logic                                ready;
    logic [egop_pkg::CH_W-1:0]           channel;
    logic signed [egop_pkg::AUD_W-1:0]   audio_in;
    logic signed [egop_pkg::AUD_W-1:0]   mod_in;

    modport source (output valid, output channel, output audio_in, output mod_in, input ready);
    modport sink   (input valid, input channel, input audio_in, input mod_in, output ready);
endinterface

@@ rtl/egop_out_if.sv @@
interface egop_out_if;
    logic                                valid;
    logic                                ready;
    logic [egop_pkg::CH_W-1:0]           channel_out;
    logic signed [egop_pkg::AUD_W-1:0]   audio_out;

    modport source (output valid, output channel_out, output audio_out, input ready);
    modport sink   (input valid, input channel_out, input audio_out, output ready);
endinterface

@@ rtl/egop_mul.sv @@
module egop_mul (
    input  logic                                 clk,
    input  logic signed [egop_pkg::MUL_A_W-1:0]  a,
    input  logic signed [egop_pkg::MUL_B_W-1:0]  b,
    output logic signed [egop_pkg::MUL_P_W-1:0]  p
);

    logic signed [egop_pkg::MUL_P_W-1:0] prod_reg;
    logic signed [egop_pkg::MUL_P_W-1:0] prod_next;

    always_comb
    begin
        prod_next = egop_pkg::MUL_P_W'(a) * egop_pkg::MUL_P_W'(b);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign p = prod_reg;

endmodule

@@ rtl/egop_state_mem.sv @@
module egop_state_mem #(
    parameter int DEPTH = egop_pkg::CHANNELS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               rd_en,
    input  logic [AW-1:0]                      rd_addr,
    output logic [egop_pkg::STATE_W-1:0]       rd_data,
    input  logic                               wr_en,
    input  logic [AW-1:0]                      wr_addr,
    input  logic [egop_pkg::STATE_W-1:0]       wr_data
);

    logic [egop_pkg::STATE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]             valid_reg;
    logic [DEPTH-1:0]             valid_next;
    logic [egop_pkg::STATE_W-1:0] rd_data_reg;

    // An entry never written since reset reads as zero
    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
            valid_next[wr_addr] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/exp_gain_oversampled_one_pole.sv @@
// Per-channel exponential gain followed by a 4x oversampled one-pole low-pass.
// Each request scales audio_in by 2^(gain_log2 + 0.1*mod_in*cv_depth), runs it
// and three zeros through the channel's filter state and returns the weighted
// sum of the four filter outputs, saturated to Q4.11, tagged with the channel.
// Items are processed one at a time: a new request is taken only back in idle,
// after the step sequence around the single shared 36x19 multiplier (the gain
// steps, the first filter input, the four filter passes, loading the result
// and the return to idle). Loading the result waits while the previous result
// is still held.
// The filter state lives in a
// CHANNELS-entry memory read at acceptance and written back at the end of the
// item; reset marks all entries as zero at once, with no clearing pass.
// Channel numbers at or above CHANNELS use entry channel modulo CHANNELS.
// A finished result waits in the output register while the next request is
// processed. Configuration writes take effect at once and belong between items.
module exp_gain_oversampled_one_pole #(
    parameter int CHANNELS = egop_pkg::CHANNELS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    egop_in_if.sink                             samples,
    egop_out_if.source                          results,
    input  logic                                cfg_wen,
    input  logic [egop_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [egop_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Configuration
    logic [egop_pkg::COEF_W-1:0]          coef_reg;
    logic [egop_pkg::NORM_W-1:0]          norm_reg;
    logic signed [egop_pkg::GAIN_W-1:0]   gain_reg;
    logic signed [egop_pkg::DEPTH_W-1:0]  depth_reg;

    // Control
    egop_pkg::state_t                     state_reg, state_next;
    logic [1:0]                           pass_reg, pass_next;
    logic                                 out_valid_reg, out_valid_next;

    // Datapath
    logic [egop_pkg::CH_W-1:0]            chan_reg, chan_next;
    logic [AW-1:0]                        idx_reg, idx_next;
    logic signed [egop_pkg::AUD_W-1:0]    audio_reg, audio_next;
    logic signed [egop_pkg::AUD_W-1:0]    mod_reg, mod_next;
    logic signed [egop_pkg::E_W-1:0]      e_reg, e_next;
    logic signed [egop_pkg::STATE_W-1:0]  x_reg, x_next;
    logic signed [egop_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic signed [egop_pkg::STATE_W-1:0]  o_reg, o_next;
    logic signed [egop_pkg::DIF_W-1:0]    dif_reg, dif_next;
    logic signed [egop_pkg::STATE_W-1:0]  st_reg, st_next;
    logic signed [egop_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic [egop_pkg::CH_W-1:0]            out_chan_reg, out_chan_next;
    logic signed [egop_pkg::AUD_W-1:0]    out_audio_reg, out_audio_next;

    logic signed [egop_pkg::MUL_A_W-1:0]  mul_a;
    logic signed [egop_pkg::MUL_B_W-1:0]  mul_b;
    logic signed [egop_pkg::MUL_P_W-1:0]  mul_p;

    logic [egop_pkg::STATE_W-1:0]         mem_rd_data;
    logic [AW-1:0]                        ch_map [egop_pkg::CH_CODES];

    logic                                 accept;
    logic                                 fin_go;
    logic signed [egop_pkg::STATE_W-1:0]  xin;
    logic signed [5:0]                    n_raw;
    logic signed [5:0]                    n_cl;
    logic [5:0]                           x_sh;
    logic signed [egop_pkg::X_SHIFT_W-1:0] x_sum;
    logic signed [egop_pkg::X_SHIFT_W-1:0] x_shr;
    logic signed [egop_pkg::MUL_P_W-1:0]  mod_term;
    logic signed [egop_pkg::MUL_P_W-1:0]  nb_full;
    logic signed [egop_pkg::STATE_W-1:0]  nb_sat;
    logic signed [egop_pkg::SUM_W-1:0]    sum_rnd;

    // Channel to state entry, worked out at elaboration
    for (genvar i = 0; i < egop_pkg::CH_CODES; i++)
    begin : g_ch_map
        assign ch_map[i] = AW'(i % CHANNELS);
    end

    assign accept = (state_reg == egop_pkg::ST_IDLE) && samples.valid;
    assign fin_go = (state_reg == egop_pkg::ST_FIN) && (!out_valid_reg || results.ready);

    assign samples.ready       = (state_reg == egop_pkg::ST_IDLE);
    assign results.valid       = out_valid_reg;
    assign results.channel_out = out_chan_reg;
    assign results.audio_out   = out_audio_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg  <= egop_pkg::POLE_COEF_RST;
            norm_reg  <= egop_pkg::POLE_NORM_RST;
            gain_reg  <= egop_pkg::GAIN_LOG2_RST;
            depth_reg <= egop_pkg::CV_DEPTH_RST;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                egop_pkg::REG_POLE_COEF: coef_reg  <= cfg_data[egop_pkg::COEF_W-1:0];
                egop_pkg::REG_POLE_NORM: norm_reg  <= cfg_data[egop_pkg::NORM_W-1:0];
                egop_pkg::REG_GAIN_LOG2: gain_reg  <= cfg_data[egop_pkg::GAIN_W-1:0];
                egop_pkg::REG_CV_DEPTH:  depth_reg <= cfg_data[egop_pkg::DEPTH_W-1:0];
                default:                 coef_reg  <= coef_reg;
            endcase
        end
    end

    // Exponent split and clamp
    assign n_raw = e_reg[egop_pkg::E_W-1:16];
    always_comb
    begin
        if (n_raw < 6'(egop_pkg::N_MIN))
            n_cl = 6'(egop_pkg::N_MIN);
        else if (n_raw > 6'(egop_pkg::N_MAX))
            n_cl = 6'(egop_pkg::N_MAX);
        else
            n_cl = n_raw;
    end
    assign x_sh  = 6'(7'sd9 - 7'(n_cl));
    assign x_sum = {{(egop_pkg::X_SHIFT_W-33){mul_p[32]}}, mul_p[32:0]}
                 + (egop_pkg::X_SHIFT_W'(1) <<< (x_sh - 6'd1));
    assign x_shr = x_sum >>> x_sh;

    assign xin      = (pass_reg == 2'd0) ? x_reg : '0;
    assign mod_term = (mul_p + (egop_pkg::MUL_P_W'(1) <<< 22)) >>> 23;
    assign nb_full  = egop_pkg::rnd16(mul_p) + egop_pkg::MUL_P_W'(o_reg);
    assign nb_sat   = egop_pkg::sat32(nb_full);
    assign sum_rnd  = (sum_reg + egop_pkg::SUM_W'(16)) >>> 5;

    // Operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            egop_pkg::ST_MOD:
            begin
                mul_a = egop_pkg::MUL_A_W'(mod_reg);
                mul_b = egop_pkg::MUL_B_W'(depth_reg);
            end
            egop_pkg::ST_SCL:
            begin
                mul_a = egop_pkg::MUL_A_W'($signed(mul_p[29:0]));
                mul_b = egop_pkg::MUL_B_W'(egop_pkg::TENTH_Q16);
            end
            egop_pkg::ST_H1:
            begin
                mul_a = egop_pkg::MUL_A_W'(egop_pkg::HORNER_C3);
                mul_b = {3'b000, e_reg[15:0]};
            end
            egop_pkg::ST_H2:
            begin
                mul_a = egop_pkg::MUL_A_W'(egop_pkg::HORNER_C2)
                      + {20'd0, mul_p[31:16]};
                mul_b = {3'b000, e_reg[15:0]};
            end
            egop_pkg::ST_H3:
            begin
                mul_a = egop_pkg::MUL_A_W'(egop_pkg::HORNER_C1)
                      + {20'd0, mul_p[31:16]};
                mul_b = {3'b000, e_reg[15:0]};
            end
            egop_pkg::ST_AUD:
            begin
                mul_a = egop_pkg::MUL_A_W'(audio_reg);
                mul_b = {2'b00, 17'(egop_pkg::HORNER_C0 + 32'(mul_p[31:16]))};
            end
            egop_pkg::ST_P1:
            begin
                mul_a = egop_pkg::MUL_A_W'(x_reg);
                mul_b = {1'b0, coef_reg};
            end
            egop_pkg::ST_P3:
            begin
                mul_a = acc_reg;
                mul_b = {2'b00, norm_reg};
            end
            egop_pkg::ST_P5:
            begin
                mul_a = egop_pkg::MUL_A_W'(o_reg);
                mul_b = egop_pkg::MUL_B_W'(egop_pkg::tap_weight(pass_reg));
            end
            egop_pkg::ST_P6:
            begin
                mul_a = egop_pkg::MUL_A_W'(dif_reg);
                mul_b = {1'b0, coef_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequencer and datapath next values
    always_comb
    begin
        state_next     = state_reg;
        pass_next      = pass_reg;
        out_valid_next = out_valid_reg;
        chan_next      = chan_reg;
        idx_next       = idx_reg;
        audio_next     = audio_reg;
        mod_next       = mod_reg;
        e_next         = e_reg;
        x_next         = x_reg;
        acc_next       = acc_reg;
        o_next         = o_reg;
        dif_next       = dif_reg;
        st_next        = st_reg;
        sum_next       = sum_reg;
        out_chan_next  = out_chan_reg;
        out_audio_next = out_audio_reg;

        if (out_valid_reg && results.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            egop_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    chan_next  = samples.channel;
                    idx_next   = ch_map[samples.channel];
                    audio_next = samples.audio_in;
                    mod_next   = samples.mod_in;
                    pass_next  = 2'd0;
                    sum_next   = '0;
                    state_next = egop_pkg::ST_MOD;
                end
            end
            egop_pkg::ST_MOD:
            begin
                st_next    = mem_rd_data;
                state_next = egop_pkg::ST_SCL;
            end
            egop_pkg::ST_SCL:
            begin
                state_next = egop_pkg::ST_EXP;
            end
            egop_pkg::ST_EXP:
            begin
                e_next     = {{(egop_pkg::E_W-egop_pkg::GAIN_W-4){gain_reg[egop_pkg::GAIN_W-1]}},
                              gain_reg, 4'b0000}
                           + egop_pkg::E_W'(mod_term);
                state_next = egop_pkg::ST_H1;
            end
            egop_pkg::ST_H1:
            begin
                state_next = egop_pkg::ST_H2;
            end
            egop_pkg::ST_H2:
            begin
                state_next = egop_pkg::ST_H3;
            end
            egop_pkg::ST_H3:
            begin
                state_next = egop_pkg::ST_AUD;
            end
            egop_pkg::ST_AUD:
            begin
                state_next = egop_pkg::ST_XIN;
            end
            egop_pkg::ST_XIN:
            begin
                x_next     = egop_pkg::sat32(egop_pkg::MUL_P_W'(x_shr));
                state_next = egop_pkg::ST_P1;
            end
            egop_pkg::ST_P1:
            begin
                state_next = egop_pkg::ST_P2;
            end
            egop_pkg::ST_P2:
            begin
                acc_next   = egop_pkg::ACC_W'(egop_pkg::rnd16(mul_p))
                           + egop_pkg::ACC_W'(st_reg);
                state_next = egop_pkg::ST_P3;
            end
            egop_pkg::ST_P3:
            begin
                state_next = egop_pkg::ST_P4;
            end
            egop_pkg::ST_P4:
            begin
                o_next     = egop_pkg::sat32(egop_pkg::rnd16(mul_p));
                state_next = egop_pkg::ST_P5;
            end
            egop_pkg::ST_P5:
            begin
                dif_next   = egop_pkg::DIF_W'(xin) - egop_pkg::DIF_W'(o_reg);
                state_next = egop_pkg::ST_P6;
            end
            egop_pkg::ST_P6:
            begin
                sum_next   = sum_reg + egop_pkg::SUM_W'(mul_p);
                state_next = egop_pkg::ST_P7;
            end
            egop_pkg::ST_P7:
            begin
                // Later passes take zero input, so the accumulator is just the state
                st_next   = nb_sat;
                acc_next  = egop_pkg::ACC_W'(nb_sat);
                pass_next = pass_reg + 2'd1;
                if (pass_reg == 2'd3)
                    state_next = egop_pkg::ST_FIN;
                else
                    state_next = egop_pkg::ST_P3;
            end
            egop_pkg::ST_FIN:
            begin
                if (fin_go)
                begin
                    out_valid_next = 1'b1;
                    out_chan_next  = chan_reg;
                    out_audio_next = egop_pkg::sat16(sum_rnd);
                    state_next     = egop_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = egop_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= egop_pkg::ST_IDLE;
            pass_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chan_reg      <= chan_next;
        idx_reg       <= idx_next;
        audio_reg     <= audio_next;
        mod_reg       <= mod_next;
        e_reg         <= e_next;
        x_reg         <= x_next;
        acc_reg       <= acc_next;
        o_reg         <= o_next;
        dif_reg       <= dif_next;
        st_reg        <= st_next;
        sum_reg       <= sum_next;
        out_chan_reg  <= out_chan_next;
        out_audio_reg <= out_audio_next;
    end

    egop_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    egop_state_mem #(
        .DEPTH (CHANNELS),
        .AW    (AW)
    ) u_state_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (ch_map[samples.channel]),
        .rd_data (mem_rd_data),
        .wr_en   (fin_go),
        .wr_addr (idx_reg),
        .wr_data (st_reg)
    );

endmodule
